[sv/clrs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clrs_pkg
// Shared types and constants of the character LCD refresh sequencer.
// ----------------------------------------------------------------------------

package clrs_pkg;

   localparam int COLUMNS_DEFAULT = 16;
   localparam int ROWS_DEFAULT    = 2;

   localparam int CMD_W      = 8;
   localparam int BASE_W     = 7;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 8;
   localparam int NIBBLE_W   = 4;

   localparam logic [CMD_W-1:0] INIT_WAKE_A   = 8'h33;
   localparam logic [CMD_W-1:0] INIT_WAKE_B   = 8'h32;
   localparam logic [CMD_W-1:0] SET_ADDR_FLAG = 8'h80;
   localparam logic [2:0]       INIT_LAST     = 3'd6;

   localparam logic [CMD_W-1:0]  FUNCTION_SET_RESET = 8'h28;
   localparam logic [CMD_W-1:0]  DISPLAY_ON_RESET   = 8'h0E;
   localparam logic [CMD_W-1:0]  CLEAR_RESET        = 8'h01;
   localparam logic [CMD_W-1:0]  ENTRY_MODE_RESET   = 8'h06;
   localparam logic [CMD_W-1:0]  CURSOR_OFF_RESET   = 8'h0C;
   localparam logic [BASE_W-1:0] LINE0_BASE_RESET   = 7'h00;
   localparam logic [BASE_W-1:0] LINE1_BASE_RESET   = 7'h40;

   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_CLEAR = 2'd2
   } req_kind_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'b001,
      PH_READY  = 3'b010,
      PH_POSUPD = 3'b100
   } phase_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_FUNCTION_SET = 3'd0,
      CSR_DISPLAY_ON   = 3'd1,
      CSR_CLEAR        = 3'd2,
      CSR_ENTRY_MODE   = 3'd3,
      CSR_CURSOR_OFF   = 3'd4,
      CSR_LINE0_BASE   = 3'd5,
      CSR_LINE1_BASE   = 3'd6
   } csr_index_type;

   // one byte waiting for the nibble register
   typedef struct packed {
      logic             err;
      logic             rs;
      logic             from_ram;
      logic             hit;
      logic [CMD_W-1:0] data;
   } stage_type;

endpackage

[sv/clrs_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clrs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------

module clrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/char_lcd_refresh_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_refresh_sequencer
// Character buffer and 4-bit bus sequencer for an HD44780-style display.
// ----------------------------------------------------------------------------
// A request item is taken while req_tready is high; a stalled byte stage
// drops it. A tick or a clear produces one byte, which leaves as two nibble
// items (high nibble first, rsp_tlast on the low nibble); a clear before init
// completes gives a single error item. The nibble output register emits one
// nibble per cycle while rsp_tready is high, and a steady stream of ticks is
// paced by it. The character buffer sits in a RAM with a registered read
// port, read when a ready tick is taken; per-entry valid flops make unwritten
// entries read as zero right after reset, with no clearing pass. Pipeline:
// request stage, byte stage (RAM data), nibble register.
// ----------------------------------------------------------------------------

module char_lcd_refresh_sequencer #(
   parameter int COLUMNS = clrs_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = clrs_pkg::ROWS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [15:0]                     req_tdata,  // buf_row, buf_col, buf_char
   input  logic [1:0]                      req_tuser,  // req_type
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,  // bus_nibble
   output logic [1:0]                      rsp_tuser,  // reg_select, not_ready_error
   output logic                            rsp_tlast,  // last_nibble
   // configuration
   input  logic                            csr_we,
   input  logic [clrs_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [clrs_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int DEPTH = ROWS * COLUMNS;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int COL_W = $clog2(COLUMNS);
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
   localparam logic [clrs_pkg::BASE_W-1:0] COL_OFFSET = clrs_pkg::BASE_W'(COLUMNS);

   // configuration registers
   logic [clrs_pkg::CMD_W-1:0]  fn_set_ff, fn_set_in;
   logic [clrs_pkg::CMD_W-1:0]  disp_on_ff, disp_on_in;
   logic [clrs_pkg::CMD_W-1:0]  clear_ff, clear_in;
   logic [clrs_pkg::CMD_W-1:0]  entry_ff, entry_in;
   logic [clrs_pkg::CMD_W-1:0]  curs_off_ff, curs_off_in;
   logic [clrs_pkg::BASE_W-1:0] line0_ff, line0_in;
   logic [clrs_pkg::BASE_W-1:0] line1_ff, line1_in;

   // sequencer state
   clrs_pkg::phase_type phase_ff, phase_in;
   logic [2:0]          step_ff, step_in;
   logic                done_ff, done_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic                vld_ff [DEPTH];
   logic                vld_in [DEPTH];

   // byte stage and nibble register
   logic                       s1_valid_ff, s1_valid_in;
   clrs_pkg::stage_type        s1_ff, s1_in;
   logic                       ob_valid_ff, ob_valid_in;
   logic                       ob_lo_ff, ob_lo_in;
   logic                       ob_err_ff, ob_err_in;
   logic                       ob_rs_ff, ob_rs_in;
   logic [clrs_pkg::CMD_W-1:0] ob_data_ff, ob_data_in;

   // request fields
   logic                       buf_row;
   logic [3:0]                 buf_col;
   logic [clrs_pkg::CMD_W-1:0] buf_char;
   clrs_pkg::req_kind_type     req_kind;

   logic                        accept;
   logic                        ob_done;
   logic                        s1_advance;
   logic                        wr_ok;
   logic [IDX_W-1:0]            wr_idx;
   logic [IDX_W-1:0]            rd_idx;
   logic                        ram_we;
   logic                        ram_re;
   logic [clrs_pkg::CMD_W-1:0]  ram_rd_data;
   logic [clrs_pkg::CMD_W-1:0]  s1_byte;
   logic [clrs_pkg::CMD_W-1:0]  init_cmd;
   logic [clrs_pkg::CMD_W-1:0]  addr_cmd;
   logic [clrs_pkg::BASE_W-1:0] line_base;
   logic [1:0]                  row_sel;

   assign buf_row  = req_tdata[0];
   assign buf_col  = req_tdata[4:1];
   assign buf_char = req_tdata[12:5];
   assign req_kind = clrs_pkg::req_kind_type'(req_tuser);

   assign ob_done    = ob_valid_ff && rsp_tready && (ob_lo_ff || ob_err_ff);
   assign s1_advance = s1_valid_ff && (!ob_valid_ff || ob_done);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign accept     = req_tvalid && req_tready;

   assign wr_ok  = ((ROWS > 1) || (buf_row == 1'b0)) && (32'(buf_col) < COLUMNS);
   assign wr_idx = IDX_W'(32'(buf_row) * COLUMNS + 32'(buf_col));
   assign rd_idx = IDX_W'(32'(row_ff) * COLUMNS + 32'(col_ff));

   always_comb begin
      unique case (step_ff)
         3'd0:    init_cmd = clrs_pkg::INIT_WAKE_A;
         3'd1:    init_cmd = clrs_pkg::INIT_WAKE_B;
         3'd2:    init_cmd = fn_set_ff;
         3'd3:    init_cmd = disp_on_ff;
         3'd4:    init_cmd = clear_ff;
         3'd5:    init_cmd = entry_ff;
         default: init_cmd = curs_off_ff;
      endcase
   end

   // rows two and three sit one line length past the first two bases
   assign row_sel = 2'(row_ff);
   always_comb begin
      unique case (row_sel)
         2'd0:    line_base = line0_ff;
         2'd1:    line_base = line1_ff;
         2'd2:    line_base = line0_ff + COL_OFFSET;
         default: line_base = line1_ff + COL_OFFSET;
      endcase
   end
   assign addr_cmd = clrs_pkg::SET_ADDR_FLAG
                   | {1'b0, line_base + clrs_pkg::BASE_W'(col_ff)};

   assign s1_byte = s1_ff.from_ram ? (s1_ff.hit ? ram_rd_data : '0) : s1_ff.data;

   always_comb begin
      fn_set_in   = fn_set_ff;
      disp_on_in  = disp_on_ff;
      clear_in    = clear_ff;
      entry_in    = entry_ff;
      curs_off_in = curs_off_ff;
      line0_in    = line0_ff;
      line1_in    = line1_ff;
      phase_in    = phase_ff;
      step_in     = step_ff;
      done_in     = done_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      vld_in      = vld_ff;
      s1_valid_in = s1_valid_ff;
      s1_in       = s1_ff;
      ob_valid_in = ob_valid_ff;
      ob_lo_in    = ob_lo_ff;
      ob_err_in   = ob_err_ff;
      ob_rs_in    = ob_rs_ff;
      ob_data_in  = ob_data_ff;
      ram_we      = 1'b0;
      ram_re      = 1'b0;

      if (csr_we) begin
         unique case (clrs_pkg::csr_index_type'(csr_addr))
            clrs_pkg::CSR_FUNCTION_SET: fn_set_in   = csr_wdata;
            clrs_pkg::CSR_DISPLAY_ON:   disp_on_in  = csr_wdata;
            clrs_pkg::CSR_CLEAR:        clear_in    = csr_wdata;
            clrs_pkg::CSR_ENTRY_MODE:   entry_in    = csr_wdata;
            clrs_pkg::CSR_CURSOR_OFF:   curs_off_in = csr_wdata;
            clrs_pkg::CSR_LINE0_BASE:   line0_in    = csr_wdata[clrs_pkg::BASE_W-1:0];
            clrs_pkg::CSR_LINE1_BASE:   line1_in    = csr_wdata[clrs_pkg::BASE_W-1:0];
            default: ;
         endcase
      end

      // nibble register: high nibble, then low nibble
      if (s1_advance) begin
         ob_valid_in = 1'b1;
         ob_lo_in    = 1'b0;
         ob_err_in   = s1_ff.err;
         ob_rs_in    = s1_ff.rs;
         ob_data_in  = s1_byte;
      end else if (ob_valid_ff && rsp_tready) begin
         if (ob_lo_ff || ob_err_ff) begin
            ob_valid_in = 1'b0;
         end else begin
            ob_lo_in = 1'b1;
         end
      end

      if (s1_advance) begin
         s1_valid_in = 1'b0;
      end

      if (accept) begin
         s1_in.err      = 1'b0;
         s1_in.rs       = 1'b0;
         s1_in.from_ram = 1'b0;
         s1_in.hit      = 1'b0;
         s1_in.data     = '0;
         unique case (req_kind)
            clrs_pkg::REQ_WRITE: begin
               if (wr_ok) begin
                  ram_we         = 1'b1;
                  vld_in[wr_idx] = 1'b1;
               end
            end
            clrs_pkg::REQ_CLEAR: begin
               s1_valid_in = 1'b1;
               if (!done_ff) begin
                  s1_in.err = 1'b1;
               end else begin
                  s1_in.data = clear_ff;
                  row_in     = '0;
                  col_in     = '0;
                  phase_in   = clrs_pkg::PH_POSUPD;
               end
            end
            clrs_pkg::REQ_TICK: begin
               unique case (phase_ff)
                  clrs_pkg::PH_IDLE: begin
                     s1_valid_in = 1'b1;
                     s1_in.data  = init_cmd;
                     if (step_ff >= clrs_pkg::INIT_LAST) begin
                        done_in  = 1'b1;
                        phase_in = clrs_pkg::PH_READY;
                     end else begin
                        step_in = step_ff + 3'd1;
                     end
                  end
                  clrs_pkg::PH_READY: begin
                     s1_valid_in    = 1'b1;
                     s1_in.rs       = 1'b1;
                     s1_in.from_ram = 1'b1;
                     s1_in.hit      = vld_ff[rd_idx];
                     ram_re         = 1'b1;
                     if (col_ff == COL_LAST) begin
                        col_in   = '0;
                        row_in   = (row_ff == ROW_LAST) ? '0 : row_ff + ROW_W'(1);
                        phase_in = clrs_pkg::PH_POSUPD;
                     end else begin
                        col_in = col_ff + COL_W'(1);
                     end
                  end
                  clrs_pkg::PH_POSUPD: begin
                     s1_valid_in = 1'b1;
                     s1_in.data  = addr_cmd;
                     phase_in    = clrs_pkg::PH_READY;
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fn_set_ff   <= clrs_pkg::FUNCTION_SET_RESET;
         disp_on_ff  <= clrs_pkg::DISPLAY_ON_RESET;
         clear_ff    <= clrs_pkg::CLEAR_RESET;
         entry_ff    <= clrs_pkg::ENTRY_MODE_RESET;
         curs_off_ff <= clrs_pkg::CURSOR_OFF_RESET;
         line0_ff    <= clrs_pkg::LINE0_BASE_RESET;
         line1_ff    <= clrs_pkg::LINE1_BASE_RESET;
         phase_ff    <= clrs_pkg::PH_IDLE;
         step_ff     <= '0;
         done_ff     <= 1'b0;
         row_ff      <= '0;
         col_ff      <= '0;
         for (int i = 0; i < DEPTH; i++) begin
            vld_ff[i] <= 1'b0;
         end
         s1_valid_ff <= 1'b0;
         ob_valid_ff <= 1'b0;
         ob_lo_ff    <= 1'b0;
         ob_err_ff   <= 1'b0;
      end else begin
         fn_set_ff   <= fn_set_in;
         disp_on_ff  <= disp_on_in;
         clear_ff    <= clear_in;
         entry_ff    <= entry_in;
         curs_off_ff <= curs_off_in;
         line0_ff    <= line0_in;
         line1_ff    <= line1_in;
         phase_ff    <= phase_in;
         step_ff     <= step_in;
         done_ff     <= done_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         vld_ff      <= vld_in;
         s1_valid_ff <= s1_valid_in;
         ob_valid_ff <= ob_valid_in;
         ob_lo_ff    <= ob_lo_in;
         ob_err_ff   <= ob_err_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff      <= s1_in;
      ob_rs_ff   <= ob_rs_in;
      ob_data_ff <= ob_data_in;
   end

   clrs_ram #(
      .WIDTH (clrs_pkg::CMD_W),
      .DEPTH (DEPTH)
   ) u_buf_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_idx),
      .wr_data (buf_char),
      .rd_en   (ram_re),
      .rd_addr (rd_idx),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = ob_valid_ff;
   assign rsp_tlast  = ob_lo_ff;
   assign rsp_tuser  = {ob_err_ff, ob_rs_ff};
   assign rsp_tdata  = {4'b0000, ob_lo_ff ? ob_data_ff[3:0] : ob_data_ff[7:4]};

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the character LCD refresh sequencer.
// ----------------------------------------------------------------------------
// Request items (ticks, buffer writes, clears, unused codes) go in through the
// request stream. A scoreboard class keeps its own copy of the display state
// and predicts the nibble items each request should produce. Every nibble that
// comes out is checked against the oldest prediction. The run starts with
// hand-picked requests. Three random phases follow, each with different
// command and line-base settings and a different mix of idle cycles on the
// two sides.
// ----------------------------------------------------------------------------

module tb;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 12;

   typedef struct packed {
      logic       rs;
      logic [3:0] nibble;
      logic       last;
      logic       err;
   } lcd_nibble_type;

   class lcd_scoreboard;
      logic [7:0]          function_set, display_on, clear_byte, entry_mode, last_init;
      logic [6:0]          base0, base1;
      clrs_pkg::phase_type phase;
      int                  init_step;
      bit                  init_done;
      int                  cur_row, cur_col;
      logic [7:0]          chars [clrs_pkg::ROWS_DEFAULT*clrs_pkg::COLUMNS_DEFAULT];
      lcd_nibble_type      pending_nibbles[$];
      int                  mismatches;

      function new();
         function_set = clrs_pkg::FUNCTION_SET_RESET;
         display_on   = clrs_pkg::DISPLAY_ON_RESET;
         clear_byte   = clrs_pkg::CLEAR_RESET;
         entry_mode   = clrs_pkg::ENTRY_MODE_RESET;
         last_init    = clrs_pkg::CURSOR_OFF_RESET;
         base0        = clrs_pkg::LINE0_BASE_RESET;
         base1        = clrs_pkg::LINE1_BASE_RESET;
         phase        = clrs_pkg::PH_IDLE;
         init_step    = 0;
         init_done    = 0;
         cur_row      = 0;
         cur_col      = 0;
         foreach (chars[i]) chars[i] = 8'h00;
         mismatches   = 0;
      endfunction

      function void write_reg(clrs_pkg::csr_index_type idx, logic [7:0] value);
         case (idx)
            clrs_pkg::CSR_FUNCTION_SET: function_set = value;
            clrs_pkg::CSR_DISPLAY_ON:   display_on   = value;
            clrs_pkg::CSR_CLEAR:        clear_byte   = value;
            clrs_pkg::CSR_ENTRY_MODE:   entry_mode   = value;
            clrs_pkg::CSR_CURSOR_OFF:   last_init    = value;
            clrs_pkg::CSR_LINE0_BASE:   base0        = value[6:0];
            clrs_pkg::CSR_LINE1_BASE:   base1        = value[6:0];
            default: ;
         endcase
      endfunction

      function void push_byte(logic rs, logic [7:0] value);
         pending_nibbles.push_back('{rs: rs, nibble: value[7:4], last: 1'b0, err: 1'b0});
         pending_nibbles.push_back('{rs: rs, nibble: value[3:0], last: 1'b1, err: 1'b0});
      endfunction

      function logic [7:0] init_command(int step);
         case (step)
            0: return clrs_pkg::INIT_WAKE_A;
            1: return clrs_pkg::INIT_WAKE_B;
            2: return function_set;
            3: return display_on;
            4: return clear_byte;
            5: return entry_mode;
            default: return last_init;
         endcase
      endfunction

      function void note_request(logic [1:0] kind, logic row, logic [3:0] col,
                                 logic [7:0] ch);
         logic [6:0] addr;
         if (kind == clrs_pkg::REQ_WRITE) begin
            chars[row*clrs_pkg::COLUMNS_DEFAULT + col] = ch;
         end else if (kind == clrs_pkg::REQ_CLEAR) begin
            if (!init_done) begin
               pending_nibbles.push_back('{rs: 1'b0, nibble: 4'h0, last: 1'b0, err: 1'b1});
            end else begin
               push_byte(1'b0, clear_byte);
               cur_row = 0;
               cur_col = 0;
               phase   = clrs_pkg::PH_POSUPD;
            end
         end else if (kind == clrs_pkg::REQ_TICK) begin
            case (phase)
               clrs_pkg::PH_IDLE: begin
                  push_byte(1'b0, init_command(init_step));
                  if (init_step == int'(clrs_pkg::INIT_LAST)) begin
                     init_done = 1;
                     phase     = clrs_pkg::PH_READY;
                  end else begin
                     init_step++;
                  end
               end
               clrs_pkg::PH_READY: begin
                  push_byte(1'b1, chars[cur_row*clrs_pkg::COLUMNS_DEFAULT + cur_col]);
                  cur_col++;
                  if (cur_col >= clrs_pkg::COLUMNS_DEFAULT) begin
                     cur_col = 0;
                     cur_row = (cur_row + 1) % clrs_pkg::ROWS_DEFAULT;
                     phase   = clrs_pkg::PH_POSUPD;
                  end
               end
               clrs_pkg::PH_POSUPD: begin
                  // line base plus column wraps to seven bits
                  addr = (cur_row == 1 ? base1 : base0) + 7'(cur_col);
                  push_byte(1'b0, clrs_pkg::SET_ADDR_FLAG | {1'b0, addr});
                  phase = clrs_pkg::PH_READY;
               end
               default: ;
            endcase
         end
      endfunction

      function void report(string what, lcd_nibble_type want, lcd_nibble_type got);
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s: expected rs=%0d nib=%h last=%0d err=%0d, %s",
                     $realtime, what, want.rs, want.nibble, want.last, want.err,
                     $sformatf("got rs=%0d nib=%h last=%0d err=%0d",
                               got.rs, got.nibble, got.last, got.err));
      endfunction

      function void check_nibble(lcd_nibble_type got);
         lcd_nibble_type want;
         if (pending_nibbles.size() == 0) begin
            report("unexpected nibble", '0, got);
            return;
         end
         want = pending_nibbles.pop_front();
         if (got.rs !== want.rs || got.nibble !== want.nibble ||
             got.last !== want.last || got.err !== want.err)
            report("nibble mismatch", want, got);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [1:0]  req_tuser = clrs_pkg::REQ_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [clrs_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [clrs_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   lcd_scoreboard board = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_cycles  = 0;

   char_lcd_refresh_sequencer DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // result side: check accepted nibbles, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            board.check_nibble('{rs: rsp_tuser[0], nibble: rsp_tdata[3:0],
                                 last: rsp_tlast, err: rsp_tuser[1]});
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   task automatic send_req(logic [1:0] kind, logic row, logic [3:0] col, logic [7:0] ch);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {3'b000, ch, col, row};
      do @(posedge clock); while (!req_tready);
      board.note_request(kind, row, col, ch);
   endtask

   task automatic send_random_req();
      int pick;
      logic [7:0] ch;
      pick = $urandom_range(99);
      ch   = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 8'hFF : 8'h00)
                                      : 8'($urandom);
      if (pick < 55)
         send_req(clrs_pkg::REQ_TICK, 1'($urandom), 4'($urandom), 8'($urandom));
      else if (pick < 88)
         send_req(clrs_pkg::REQ_WRITE, 1'($urandom), 4'($urandom), ch);
      else if (pick < 94)
         send_req(clrs_pkg::REQ_CLEAR, 1'($urandom), 4'($urandom), 8'($urandom));
      else
         send_req(REQ_UNUSED, 1'($urandom), 4'($urandom), ch);
   endtask

   // wait out every predicted nibble plus the pipeline of ignored items
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending_nibbles.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(clrs_pkg::csr_index_type idx, logic [7:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      board.write_reg(idx, value);
   endtask

   task automatic write_all_csrs(logic [7:0] values [7]);
      for (int i = 0; i < 7; i++) write_csr(clrs_pkg::csr_index_type'(i), values[i]);
      csr_we <= 1'b0;
   endtask

   task automatic random_phase(int send_pct, int recv_pct, logic [7:0] values [7],
                               int count);
      drain();
      write_all_csrs(values);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int i = 0; i < count; i++) begin
         send_random_req();
      end
   endtask

   initial begin
      logic [7:0] settings [7];
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // init commands come from these before the display is ready
      write_csr(clrs_pkg::CSR_FUNCTION_SET, 8'hFF);
      write_csr(clrs_pkg::CSR_DISPLAY_ON, 8'h00);
      write_csr(clrs_pkg::CSR_ENTRY_MODE, 8'($urandom));
      write_csr(clrs_pkg::CSR_CURSOR_OFF, 8'($urandom));
      csr_we <= 1'b0;

      send_idle_pct = 38;
      recv_idle_pct = 49;
      send_req(clrs_pkg::REQ_CLEAR, 1'b0, 4'h0, 8'h00);          // clear before init: error
      send_req(clrs_pkg::REQ_WRITE, 1'b0, 4'h0, 8'hFF);
      send_req(clrs_pkg::REQ_WRITE, 1'b1, 4'hF, 8'hA5);
      send_req(REQ_UNUSED, 1'b1, 4'hF, 8'hFF);
      send_req(clrs_pkg::REQ_WRITE, 1'b0, 4'h2, 8'h5A);
      repeat (7) send_req(clrs_pkg::REQ_TICK, 1'b0, 4'h0, 8'h00);
      send_req(clrs_pkg::REQ_CLEAR, 1'b1, 4'hF, 8'hFF);
      repeat (4) send_req(clrs_pkg::REQ_TICK, 1'b0, 4'h0, 8'h00);
      send_req(clrs_pkg::REQ_CLEAR, 1'b0, 4'h0, 8'h00);
      send_req(clrs_pkg::REQ_TICK, 1'b0, 4'h0, 8'h00);

      // top of range: address sums overflow seven bits
      settings = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
      random_phase(38, 49, settings, 230);
      settings = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      random_phase(49, 38, settings, 230);
      foreach (settings[i]) settings[i] = 8'($urandom);
      random_phase(0, 0, settings, 230);

      drain();
      if (board.mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

[char_lcd_refresh_sequencer.f]
sv/clrs_pkg.sv
sv/clrs_ram.sv
sv/char_lcd_refresh_sequencer.sv
bench/tb.sv
